// ===== hdl/rmsg_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsg_pkg
// Shared constants, command and status types, and the quarter-wave sine
// table of the ramped multitone stimulus generator.
// ----------------------------------------------------------------------------
package rmsg_pkg;

    // Sizing
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int COUNT_BITS       = 24;

    localparam int TAB_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int QTAB_DEPTH  = SINE_TABLE_DEPTH / 4;
    localparam int QIDX_BITS   = TAB_BITS - 2;
    localparam int ANGLE_UNIT  = 65536 / SINE_TABLE_DEPTH;

    localparam int NUM_TONES     = 5;
    localparam int TONE_IDX_BITS = $clog2(NUM_TONES);
    localparam int STEP_BITS     = 32;
    localparam int MODE_BITS     = 2;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 32;

    // Datapath word widths
    localparam int SINE_BITS   = 16;
    localparam int MAG_BITS    = SINE_BITS - 1;
    localparam int MOD_BITS    = 17;
    localparam int ACC_BITS    = 19;
    localparam int MA_BITS     = 20;
    localparam int MB_BITS     = 18;
    localparam int PROD_BITS   = MA_BITS + MB_BITS;
    localparam int POLY_BITS   = 15;
    localparam int QUOT_BITS   = 15;
    localparam int ANGLE_BITS  = 16;
    localparam int WIN_BITS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int CNT_BITS    = 4;

    // Fixed-point constants
    localparam int AMP_TONE   = 46341;
    localparam int AMP_AM     = 37837;
    localparam int AMP_FIVE   = 20724;
    localparam int MOD_BIAS   = 32768;
    localparam int WIN_ONE    = 32768;
    localparam int QUARTER    = 16384;
    localparam int SINE_MAX   = 32767;
    localparam int COEF_K77   = 77;
    localparam int COEF_K1306 = 1306;
    localparam int COEF_K10583 = 10583;
    localparam int COEF_K25736 = 25736;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // Mode codes
    localparam logic [MODE_BITS-1:0] MODE_TONE   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_AM     = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FIVE   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_SILENT = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE         = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CARRIER_STEP = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_STEP_A  = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_STEP_B  = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_STEP_C  = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_STEP_D  = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_LEN     = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_LEN    = 4'd7;

    // Tone accumulator indexes
    localparam logic [TONE_IDX_BITS-1:0] PH_CARRIER = 3'd0;
    localparam logic [TONE_IDX_BITS-1:0] PH_SIDE_A  = 3'd1;

    // Polynomial coefficient selects
    localparam logic [TONE_IDX_BITS-1:0] COEF_SEL_C3 = 3'd0;
    localparam logic [TONE_IDX_BITS-1:0] COEF_SEL_C2 = 3'd1;
    localparam logic [TONE_IDX_BITS-1:0] COEF_SEL_C1 = 3'd2;

    // Sequencer limits
    localparam logic [CNT_BITS-1:0] SIDE_LAST = CNT_BITS'(NUM_TONES - 2);
    localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(QUOT_BITS - 1);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SINE_LOAD,
        OP_SINE_ADD,
        OP_MOD_LOAD,
        OP_MUL,
        OP_SCALE,
        OP_ACC_ZERO,
        OP_SET_PAST,
        OP_WIN_ONE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ANGLE,
        OP_U2,
        OP_POLY,
        OP_WIN_CALC,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [1:0] {
        MA_ACC,
        MA_U,
        MA_P,
        MA_K77
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_AMP_TONE,
        MB_AMP_AM,
        MB_AMP_FIVE,
        MB_MOD,
        MB_WIN,
        MB_U,
        MB_U2
    } mul_b_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_M0_MUL,
        ST_M1_MOD,
        ST_M1_MUL,
        ST_M1_T,
        ST_M1_AMP,
        ST_M2_ADD,
        ST_M2_MUL,
        ST_SCALE,
        ST_WIN,
        ST_DIV,
        ST_ANGLE,
        ST_SQ,
        ST_U2,
        ST_P1M,
        ST_P1,
        ST_P2M,
        ST_P2,
        ST_P3M,
        ST_P3,
        ST_SM,
        ST_WCALC,
        ST_APPLY,
        ST_RESULT,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic                     accept;
        logic                     out_load;
        dp_op_t                   op;
        logic [TONE_IDX_BITS-1:0] idx;
        mul_a_t                   ma;
        mul_b_t                   mb;
    } dp_cmd_t;

    typedef struct packed {
        logic                 past_end;
        logic                 ramp_on;
        logic [MODE_BITS-1:0] mode;
    } dp_stat_t;

    // Quarter-wave polynomial, evaluated at elaboration only
    function automatic int poly_sine(input int u);
        int u2;
        int p;
        int s;
        u2 = (u * u) >>> 14;
        p  = COEF_K1306 - ((COEF_K77 * u2) >>> 14);
        p  = COEF_K10583 - ((p * u2) >>> 14);
        p  = COEF_K25736 - ((p * u2) >>> 14);
        s  = (p * u) >>> 13;
        if (s > SINE_MAX)
        begin
            s = SINE_MAX;
        end
        return s;
    endfunction

    typedef logic [QTAB_DEPTH-1:0][MAG_BITS-1:0] qtab_t;

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int j = 0; j < QTAB_DEPTH; j++)
        begin
            t[j] = MAG_BITS'(poly_sine(j * ANGLE_UNIT));
        end
        return t;
    endfunction

    localparam qtab_t               SINE_QTR  = build_qtab();
    localparam logic [MAG_BITS-1:0] SINE_PEAK = MAG_BITS'(poly_sine(QUARTER));

endpackage

// ===== hdl/ramped_multitone_stimulus_generator.sv =====
// ----------------------------------------------------------------------------
// ramped_multitone_stimulus_generator
// DDS stimulus source: pure, amplitude-modulated or five-tone signal shaped
// by raised-cosine onset and offset ramps, one Q3.12 sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each transfer is one tick; restart
//   set clears the sample counter and all phases so that tick gives sample 0.
//   Output channel (out_valid / out_stall): one result per tick carrying
//   sample, last_sample and past_end. Past the end of the stimulus the
//   sample is zero, past_end is set and counter and phases hold.
//   Configuration: cfg_write with cfg_index / cfg_data, only while idle.
// Timing:
//   One tick at a time through a single shared multiplier and sine table.
//   A tick past the end only sets the past-end result; otherwise the work
//   depends on the mode, and a sample inside a ramp adds the bit-serial
//   ramp divider and the cosine polynomial.
//   The result sits in an output register, so a stalled receiver only
//   blocks the next tick once that tick's own result is ready.
// Reset:
//   rst_n clears all configuration registers, the counter and the phases;
//   no output is valid afterwards.
// ----------------------------------------------------------------------------
module ramped_multitone_stimulus_generator
    import rmsg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last_sample,
    output logic                          past_end
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rmsg_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rmsg_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .restart     (restart),
        .cmd         (cmd),
        .stat        (stat),
        .sample      (sample),
        .last_sample (last_sample),
        .past_end    (past_end)
    );

    // A sample beyond the end is silent and never marked final
    a_past_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && past_end) |-> (sample == '0 && !last_sample))
        else $error("past-end result carries a sample or a final flag");

    // The block is busy in the cycle after an input transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again without a busy cycle");

    // A new result only appears while a tick is being worked on
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised without a tick in progress");

endmodule

// ===== hdl/rmsg_dp.sv =====
// ----------------------------------------------------------------------------
// rmsg_dp
// Datapath: configuration registers, sample counter, tone accumulators,
// shared multiplier, ramp divider, window polynomial and output register.
// ----------------------------------------------------------------------------
module rmsg_dp
    import rmsg_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                            restart,
    input  dp_cmd_t                         cmd,
    output dp_stat_t                        stat,
    output logic signed [SAMPLE_BITS-1:0]   sample,
    output logic                            last_sample,
    output logic                            past_end
);

    // Configuration
    logic [MODE_BITS-1:0]  mode_reg;
    logic [STEP_BITS-1:0]  step_reg [NUM_TONES];
    logic [COUNT_BITS-1:0] ramp_reg;
    logic [COUNT_BITS-1:0] total_reg;

    // Stimulus state
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PHASE_BITS-1:0] phase_reg [NUM_TONES];
    logic [PHASE_BITS-1:0] phase_next [NUM_TONES];

    // Working registers
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [MOD_BITS-1:0]           mod_reg, mod_next;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic [POLY_BITS-1:0]          u_reg, u_next;
    logic [POLY_BITS-1:0]          u2_reg, u2_next;
    logic [POLY_BITS-1:0]          p_reg, p_next;
    logic                          neg_reg, neg_next;
    logic [WIN_BITS-1:0]           w_reg, w_next;
    logic [COUNT_BITS-1:0]         rem_reg, rem_next;
    logic [QUOT_BITS-1:0]          quot_reg, quot_next;
    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;
    logic                          rlast_reg, rlast_next;
    logic                          rpast_reg, rpast_next;

    // Output register
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;
    logic                          past_reg;

    // Combinational helpers
    logic [PHASE_BITS-1:0]        tone_phase;
    logic [TAB_BITS-1:0]          tab_k;
    logic [1:0]                   tab_quad;
    logic [QIDX_BITS-1:0]         tab_low;
    logic [QIDX_BITS:0]           tab_j;
    logic [MAG_BITS-1:0]          tab_mag;
    logic signed [SINE_BITS-1:0]  tone_sine;
    logic signed [MA_BITS-1:0]    mul_a;
    logic signed [MB_BITS-1:0]    mul_b;
    logic signed [PROD_BITS-1:0]  mul_p;
    logic [COUNT_BITS:0]          rem_dbl;
    logic                         rem_ge;
    logic [ANGLE_BITS-1:0]        angle;
    logic [POLY_BITS-1:0]         coef;
    logic [MOD_BITS-1:0]          s_raw;
    logic [MAG_BITS-1:0]          s_clip;
    logic [MOD_BITS-1:0]          w_diff;
    logic signed [PROD_BITS-1:0]  res_wide;
    logic                         n_lt_r;
    logic                         n_tail;
    logic                         last_now;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TONE;
            ramp_reg  <= '0;
            total_reg <= '0;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                step_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:         mode_reg    <= cfg_data[MODE_BITS-1:0];
                REG_CARRIER_STEP: step_reg[0] <= cfg_data[STEP_BITS-1:0];
                REG_SIDE_STEP_A:  step_reg[1] <= cfg_data[STEP_BITS-1:0];
                REG_SIDE_STEP_B:  step_reg[2] <= cfg_data[STEP_BITS-1:0];
                REG_SIDE_STEP_C:  step_reg[3] <= cfg_data[STEP_BITS-1:0];
                REG_SIDE_STEP_D:  step_reg[4] <= cfg_data[STEP_BITS-1:0];
                REG_RAMP_LEN:     ramp_reg    <= cfg_data[COUNT_BITS-1:0];
                REG_TOTAL_LEN:    total_reg   <= cfg_data[COUNT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Status towards the sequencer
    assign n_lt_r   = count_reg < ramp_reg;
    assign n_tail   = ({1'b0, count_reg} + {1'b0, ramp_reg}) > {1'b0, total_reg};
    assign last_now = ({1'b0, count_reg} + (COUNT_BITS+1)'(1)) == {1'b0, total_reg};

    assign stat.past_end = count_reg >= total_reg;
    assign stat.ramp_on  = (ramp_reg != '0) && (n_lt_r || n_tail);
    assign stat.mode     = mode_reg;

    // Quarter-wave table lookup with quadrant mirroring
    assign tone_phase = phase_reg[cmd.idx];
    assign tab_k      = tone_phase[PHASE_BITS-1 -: TAB_BITS];
    assign tab_quad   = tab_k[TAB_BITS-1 -: 2];
    assign tab_low    = tab_k[QIDX_BITS-1:0];
    assign tab_j      = tab_quad[0] ? ((QIDX_BITS+1)'(QTAB_DEPTH) - {1'b0, tab_low})
                                    : {1'b0, tab_low};
    assign tab_mag    = tab_j[QIDX_BITS] ? SINE_PEAK : SINE_QTR[tab_j[QIDX_BITS-1:0]];
    assign tone_sine  = tab_quad[1] ? -$signed({1'b0, tab_mag}) : $signed({1'b0, tab_mag});

    // Shared multiplier operand selection
    always_comb
    begin
        case (cmd.ma)
            MA_ACC:  mul_a = MA_BITS'(acc_reg);
            MA_U:    mul_a = $signed(MA_BITS'(u_reg));
            MA_P:    mul_a = $signed(MA_BITS'(p_reg));
            MA_K77:  mul_a = MA_BITS'(COEF_K77);
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.mb)
            MB_AMP_TONE: mul_b = MB_BITS'(AMP_TONE);
            MB_AMP_AM:   mul_b = MB_BITS'(AMP_AM);
            MB_AMP_FIVE: mul_b = MB_BITS'(AMP_FIVE);
            MB_MOD:      mul_b = $signed(MB_BITS'(mod_reg));
            MB_WIN:      mul_b = $signed(MB_BITS'(w_reg));
            MB_U:        mul_b = $signed(MB_BITS'(u_reg));
            MB_U2:       mul_b = $signed(MB_BITS'(u2_reg));
            default:     mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Restoring divider step
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, ramp_reg};

    // Window angle folded onto the quarter wave
    assign angle = ANGLE_BITS'(QUARTER) + ANGLE_BITS'(quot_reg);

    always_comb
    begin
        case (cmd.idx)
            COEF_SEL_C3: coef = POLY_BITS'(COEF_K1306);
            COEF_SEL_C2: coef = POLY_BITS'(COEF_K10583);
            COEF_SEL_C1: coef = POLY_BITS'(COEF_K25736);
            default:     coef = '0;
        endcase
    end

    // Window weight from the polynomial result
    assign s_raw  = MOD_BITS'(prod_reg >>> 13);
    assign s_clip = (s_raw > MOD_BITS'(SINE_MAX)) ? MAG_BITS'(SINE_MAX) : s_raw[MAG_BITS-1:0];
    assign w_diff = neg_reg ? (MOD_BITS'(WIN_ONE) + MOD_BITS'(s_clip))
                            : (MOD_BITS'(WIN_ONE) - MOD_BITS'(s_clip));

    assign res_wide = prod_reg >>> 18;

    // Next values of the working registers
    always_comb
    begin
        acc_next   = acc_reg;
        mod_next   = mod_reg;
        prod_next  = prod_reg;
        u_next     = u_reg;
        u2_next    = u2_reg;
        p_next     = p_reg;
        neg_next   = neg_reg;
        w_next     = w_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        res_next   = res_reg;
        rlast_next = rlast_reg;
        rpast_next = rpast_reg;
        count_next = count_reg;
        for (int i = 0; i < NUM_TONES; i++)
        begin
            phase_next[i] = phase_reg[i];
        end

        // Clear counter and phases on a restart transfer
        if (cmd.accept && restart)
        begin
            count_next = '0;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                phase_next[i] = '0;
            end
        end

        case (cmd.op)
            OP_SINE_LOAD: acc_next = ACC_BITS'(tone_sine);
            OP_SINE_ADD:  acc_next = acc_reg + ACC_BITS'(tone_sine);
            OP_MOD_LOAD:  mod_next = MOD_BITS'(MOD_BIAS) + MOD_BITS'(tone_sine);
            OP_MUL:       prod_next = mul_p;
            OP_SCALE:     acc_next = ACC_BITS'(prod_reg >>> 15);
            OP_ACC_ZERO:  acc_next = '0;
            OP_SET_PAST:
            begin
                res_next   = '0;
                rlast_next = 1'b0;
                rpast_next = 1'b1;
            end
            OP_WIN_ONE:   w_next = WIN_BITS'(WIN_ONE);
            OP_DIV_INIT:
            begin
                rem_next  = n_lt_r ? count_reg : (total_reg - count_reg);
                quot_next = '0;
            end
            OP_DIV_STEP:
            begin
                rem_next  = rem_ge ? COUNT_BITS'(rem_dbl - {1'b0, ramp_reg})
                                   : rem_dbl[COUNT_BITS-1:0];
                quot_next = {quot_reg[QUOT_BITS-2:0], rem_ge};
            end
            OP_ANGLE:
            begin
                u_next   = angle[14] ? (POLY_BITS'(QUARTER) - POLY_BITS'(angle[13:0]))
                                     : POLY_BITS'(angle[13:0]);
                neg_next = angle[15];
            end
            OP_U2:        u2_next = POLY_BITS'(prod_reg >>> 14);
            OP_POLY:      p_next = coef - POLY_BITS'(prod_reg >>> 14);
            OP_WIN_CALC:  w_next = w_diff[WIN_BITS:1];
            OP_RESULT:
            begin
                // Saturate the windowed sample, then advance counter and phases
                if (res_wide > PROD_BITS'(SAMPLE_MAX))
                begin
                    res_next = SAMPLE_BITS'(SAMPLE_MAX);
                end
                else if (res_wide < PROD_BITS'(SAMPLE_MIN))
                begin
                    res_next = SAMPLE_BITS'(SAMPLE_MIN);
                end
                else
                begin
                    res_next = SAMPLE_BITS'(res_wide);
                end
                rlast_next = last_now;
                rpast_next = 1'b0;
                if (count_reg != '1)
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
                for (int i = 0; i < NUM_TONES; i++)
                begin
                    phase_next[i] = phase_reg[i] + PHASE_BITS'(step_reg[i]);
                end
            end
            default: ;
        endcase
    end

    // Hold counter and phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                phase_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                phase_reg[i] <= phase_next[i];
            end
        end
    end

    // Working registers carry no reset
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mod_reg   <= mod_next;
        prod_reg  <= prod_next;
        u_reg     <= u_next;
        u2_reg    <= u2_next;
        p_reg     <= p_next;
        neg_reg   <= neg_next;
        w_reg     <= w_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        res_reg   <= res_next;
        rlast_reg <= rlast_next;
        rpast_reg <= rpast_next;
    end

    // Output register, loaded when the previous result has gone
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sample_reg <= res_reg;
            last_reg   <= rlast_reg;
            past_reg   <= rpast_reg;
        end
    end

    assign sample      = sample_reg;
    assign last_sample = last_reg;
    assign past_end    = past_reg;

endmodule

// ===== hdl/rmsg_ctl.sv =====
// ----------------------------------------------------------------------------
// rmsg_ctl
// Sequencer: steps the datapath through tone synthesis, ramp division,
// window polynomial and scaling for one sample, and owns the handshakes.
// ----------------------------------------------------------------------------
module rmsg_ctl
    import rmsg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.past_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    case (stat.mode)
                        MODE_TONE: state_next = ST_M0_MUL;
                        MODE_AM:   state_next = ST_M1_MOD;
                        MODE_FIVE:
                        begin
                            state_next = ST_M2_ADD;
                            cnt_next   = '0;
                        end
                        default:   state_next = ST_WIN;
                    endcase
                end
            end
            ST_M0_MUL: state_next = ST_SCALE;
            ST_M1_MOD: state_next = ST_M1_MUL;
            ST_M1_MUL: state_next = ST_M1_T;
            ST_M1_T:   state_next = ST_M1_AMP;
            ST_M1_AMP: state_next = ST_SCALE;
            ST_M2_ADD:
            begin
                if (cnt_reg == SIDE_LAST)
                begin
                    state_next = ST_M2_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            ST_M2_MUL: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_WIN;
            ST_WIN:
            begin
                if (stat.ramp_on)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_ANGLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            ST_ANGLE:  state_next = ST_SQ;
            ST_SQ:     state_next = ST_U2;
            ST_U2:     state_next = ST_P1M;
            ST_P1M:    state_next = ST_P1;
            ST_P1:     state_next = ST_P2M;
            ST_P2M:    state_next = ST_P2;
            ST_P2:     state_next = ST_P3M;
            ST_P3M:    state_next = ST_P3;
            ST_P3:     state_next = ST_SM;
            ST_SM:     state_next = ST_WCALC;
            ST_WCALC:  state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_RESULT;
            ST_RESULT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd.accept   = 1'b0;
        cmd.out_load = 1'b0;
        cmd.op       = OP_NONE;
        cmd.idx      = PH_CARRIER;
        cmd.ma       = MA_ACC;
        cmd.mb       = MB_AMP_TONE;
        case (state_reg)
            ST_IDLE:   cmd.accept = in_valid;
            ST_CHECK:
            begin
                if (stat.past_end)
                begin
                    cmd.op = OP_SET_PAST;
                end
                else if (stat.mode == MODE_SILENT)
                begin
                    cmd.op = OP_ACC_ZERO;
                end
                else
                begin
                    cmd.op  = OP_SINE_LOAD;
                    cmd.idx = PH_CARRIER;
                end
            end
            ST_M0_MUL:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_ACC;
                cmd.mb = MB_AMP_TONE;
            end
            ST_M1_MOD:
            begin
                cmd.op  = OP_MOD_LOAD;
                cmd.idx = PH_SIDE_A;
            end
            ST_M1_MUL:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_ACC;
                cmd.mb = MB_MOD;
            end
            ST_M1_T:   cmd.op = OP_SCALE;
            ST_M1_AMP:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_ACC;
                cmd.mb = MB_AMP_AM;
            end
            ST_M2_ADD:
            begin
                cmd.op  = OP_SINE_ADD;
                cmd.idx = PH_SIDE_A + cnt_reg[TONE_IDX_BITS-1:0];
            end
            ST_M2_MUL:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_ACC;
                cmd.mb = MB_AMP_FIVE;
            end
            ST_SCALE:  cmd.op = OP_SCALE;
            ST_WIN:    cmd.op = stat.ramp_on ? OP_DIV_INIT : OP_WIN_ONE;
            ST_DIV:    cmd.op = OP_DIV_STEP;
            ST_ANGLE:  cmd.op = OP_ANGLE;
            ST_SQ:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_U;
                cmd.mb = MB_U;
            end
            ST_U2:     cmd.op = OP_U2;
            ST_P1M:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_K77;
                cmd.mb = MB_U2;
            end
            ST_P1:
            begin
                cmd.op  = OP_POLY;
                cmd.idx = COEF_SEL_C3;
            end
            ST_P2M:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_P;
                cmd.mb = MB_U2;
            end
            ST_P2:
            begin
                cmd.op  = OP_POLY;
                cmd.idx = COEF_SEL_C2;
            end
            ST_P3M:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_P;
                cmd.mb = MB_U2;
            end
            ST_P3:
            begin
                cmd.op  = OP_POLY;
                cmd.idx = COEF_SEL_C1;
            end
            ST_SM:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_P;
                cmd.mb = MB_U;
            end
            ST_WCALC:  cmd.op = OP_WIN_CALC;
            ST_APPLY:
            begin
                cmd.op = OP_MUL;
                cmd.ma = MA_ACC;
                cmd.mb = MB_WIN;
            end
            ST_RESULT: cmd.op = OP_RESULT;
            ST_FINISH: cmd.out_load = out_free;
            default:   ;
        endcase
    end

    // Output valid: set on load, drop once the receiver takes the transfer
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// ===== test/ramped_multitone_stimulus_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_multitone_stimulus_generator_tb
// Drives ticks into the stimulus generator and checks every sample it returns
// against a cycle-free fixed-point model of the tone, modulation, five-tone
// and ramp arithmetic. The run covers directed corner settings, random
// settings under several idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ramped_multitone_stimulus_generator_tb;
    import rmsg_pkg::*;

    localparam int     LIMIT_CYCLES  = 600000;
    // the slowest tick is five-tone work plus ramp work
    localparam int     SETTLE_CYCLES = 60;
    localparam int     HOLD_CYCLES   = 400;
    localparam longint TONE_GAIN     = 46341;
    localparam longint AM_GAIN       = 37837;
    localparam longint FIVE_GAIN     = 20724;
    localparam longint UNITY         = 32768;
    localparam longint COUNT_TOP     = (longint'(1) << COUNT_BITS) - 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last;
        logic                          past;
    } tick_result_t;

    // DUT connections
    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_write   = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data    = '0;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic                          restart     = 1'b0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
    logic                          past_end;

    // Register mirror and generator state of the model
    logic [MODE_BITS-1:0]  mode_q         = '0;
    logic [STEP_BITS-1:0]  carrier_step_q = '0;
    logic [STEP_BITS-1:0]  side_step_q [4] = '{default: '0};
    logic [COUNT_BITS-1:0] ramp_len_q     = '0;
    logic [COUNT_BITS-1:0] total_len_q    = '0;
    logic [COUNT_BITS-1:0] sample_cnt     = '0;
    logic [PHASE_BITS-1:0] carrier_ph     = '0;
    logic [PHASE_BITS-1:0] side_ph [4]    = '{default: '0};

    tick_result_t pending_samples [$];

    int errors          = 0;
    int ticks_sent      = 0;
    int samples_checked = 0;
    int settings_seen   = 0;
    int cycles          = 0;
    int hold_left       = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    ramped_multitone_stimulus_generator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .past_end    (past_end)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung block
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d samples outstanding",
                     cycles, pending_samples.size());
            $display("ramped_multitone_stimulus_generator test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Odd 7th-order polynomial on the quarter wave, mirrored by quadrant
    function automatic longint quarter_sine(input logic [15:0] angle);
        longint quad;
        longint rem;
        longint u;
        longint u2;
        longint p;
        longint s;
        quad = angle[15:14];
        rem  = angle[13:0];
        u    = angle[14] ? 16384 - rem : rem;
        u2   = (u * u) >> 14;
        p    = 1306 - ((77 * u2) >> 14);
        p    = 10583 - ((p * u2) >> 14);
        p    = 25736 - ((p * u2) >> 14);
        s    = (p * u) >> 13;
        if (s > 32767)
        begin
            s = 32767;
        end
        return (quad >= 2) ? -s : s;
    endfunction

    // Table lookup: phase truncated to a table index, index back to an angle
    function automatic longint table_tone(input logic [PHASE_BITS-1:0] phase);
        longint k;
        k = (longint'(phase) * SINE_TABLE_DEPTH) >> PHASE_BITS;
        return quarter_sine(16'((k << 16) / SINE_TABLE_DEPTH));
    endfunction

    // Raised-cosine weight for distance m into a ramp of length len
    function automatic longint ramp_gain(input longint m, input longint len);
        return (UNITY - quarter_sine(16'(16384 + (m << 15) / len))) / 2;
    endfunction

    // Work out the sample for one tick and advance the counter and phases
    function automatic tick_result_t next_sample(input logic rs);
        tick_result_t res;
        longint       n;
        longint       total;
        longint       ramp;
        longint       c;
        longint       v;
        longint       w;
        longint       acc;
        longint       y;
        res = '0;
        if (rs)
        begin
            sample_cnt = '0;
            carrier_ph = '0;
            for (int i = 0; i < 4; i++)
            begin
                side_ph[i] = '0;
            end
        end
        n     = sample_cnt;
        total = total_len_q;
        ramp  = ramp_len_q;

        // past the end: zero sample, state holds
        if (n >= total)
        begin
            res.past = 1'b1;
            return res;
        end

        c = table_tone(carrier_ph);
        v = 0;
        w = UNITY;
        case (mode_q)
            MODE_TONE:
            begin
                v = (TONE_GAIN * c) >>> 15;
            end
            MODE_AM:
            begin
                v = (c * (UNITY + table_tone(side_ph[0]))) >>> 15;
                v = (AM_GAIN * v) >>> 15;
            end
            MODE_FIVE:
            begin
                acc = c;
                for (int i = 0; i < 4; i++)
                begin
                    acc += table_tone(side_ph[i]);
                end
                v = (FIVE_GAIN * acc) >>> 15;
            end
            default:
            begin
                v = 0;
            end
        endcase

        // onset ramp takes priority where the two ramps overlap
        if (ramp != 0)
        begin
            if (n < ramp)
            begin
                w = ramp_gain(n, ramp);
            end
            else if (n > total - ramp)
            begin
                w = ramp_gain(total - n, ramp);
            end
        end

        y = (v * w) >>> 18;
        if (y > 32767)
        begin
            y = 32767;
        end
        if (y < -32768)
        begin
            y = -32768;
        end
        res.value = SAMPLE_BITS'(y);
        res.last  = (n + 1 == total);

        if (sample_cnt < COUNT_TOP)
        begin
            sample_cnt = sample_cnt + 1'b1;
        end
        carrier_ph = carrier_ph + carrier_step_q;
        for (int i = 0; i < 4; i++)
        begin
            side_ph[i] = side_ph[i] + side_step_q[i];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver stall: long hold-off first, otherwise random
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("Mismatch on sample %0d: %s is %0d, want %0d",
                 samples_checked, what, got, want);
        errors++;
    endtask

    // Compare each output transfer with the oldest predicted sample
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                report_mismatch("unexpected sample", sample, 0);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample !== want.value)
                begin
                    report_mismatch("sample", sample, want.value);
                end
                if (last_sample !== want.last)
                begin
                    report_mismatch("last_sample", last_sample, want.last);
                end
                if (past_end !== want.past)
                begin
                    report_mismatch("past_end", past_end, want.past);
                end
            end
            samples_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Input side and configuration
    // ------------------------------------------------------------------

    task automatic set_pressure(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Offer one tick; valid is left high so back-to-back ticks stay high
    task automatic send_tick(input logic rs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_samples.push_back(next_sample(rs));
        ticks_sent++;
    endtask

    // Drop valid, wait for every sample, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        restart  <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it; the caller drops the write enable
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_MODE:         mode_q         = data[MODE_BITS-1:0];
            REG_CARRIER_STEP: carrier_step_q = data;
            REG_SIDE_STEP_A:  side_step_q[0] = data;
            REG_SIDE_STEP_B:  side_step_q[1] = data;
            REG_SIDE_STEP_C:  side_step_q[2] = data;
            REG_SIDE_STEP_D:  side_step_q[3] = data;
            REG_RAMP_LEN:     ramp_len_q     = data[COUNT_BITS-1:0];
            REG_TOTAL_LEN:    total_len_q    = data[COUNT_BITS-1:0];
            default:          ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_DATA_BITS-1:0] mode,
                                input logic [CFG_DATA_BITS-1:0] carrier,
                                input logic [CFG_DATA_BITS-1:0] step_a,
                                input logic [CFG_DATA_BITS-1:0] step_b,
                                input logic [CFG_DATA_BITS-1:0] step_c,
                                input logic [CFG_DATA_BITS-1:0] step_d,
                                input logic [CFG_DATA_BITS-1:0] ramp,
                                input logic [CFG_DATA_BITS-1:0] total);
        write_reg(REG_MODE, mode);
        write_reg(REG_CARRIER_STEP, carrier);
        write_reg(REG_SIDE_STEP_A, step_a);
        write_reg(REG_SIDE_STEP_B, step_b);
        write_reg(REG_SIDE_STEP_C, step_c);
        write_reg(REG_SIDE_STEP_D, step_d);
        write_reg(REG_RAMP_LEN, ramp);
        write_reg(REG_TOTAL_LEN, total);
        cfg_write <= 1'b0;
        settings_seen++;
    endtask

    function automatic logic [STEP_BITS-1:0] draw_step();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return STEP_BITS'($urandom_range(1, 1 << 26));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COUNT_BITS-1:0] random_length(input int top);
        case ($urandom_range(11))
            0:       return '0;
            1:       return '1;
            default: return COUNT_BITS'($urandom_range(1, top));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        set_pressure(0, 0);

        // registers at reset: zero length, every tick lies past the end
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();

        // pure tone without ramps, run through the last sample and beyond
        program_regs(CFG_DATA_BITS'(MODE_TONE), 32'h0800_0000, 0, 0, 0, 0, 0, 6);
        send_tick(1'b1);
        repeat (7) send_tick(1'b0);
        wait_idle();

        // five tones at steps from the smallest to the widest, onset and offset ramps overlap
        program_regs(CFG_DATA_BITS'(MODE_FIVE), 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h1234_5678, 32'h0000_0001, 32'hC000_0000, 5, 6);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        wait_idle();

        // silence inside a ramp
        program_regs(CFG_DATA_BITS'(MODE_SILENT), 32'h0400_0000, 32'h0100_0000,
                     0, 0, 0, 3, 4);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();

        // upper data bits are dropped and unused indexes are ignored
        write_reg(REG_MODE, 32'hFFFF_FFFD);
        for (int i = REG_TOTAL_LEN + 1; i < (1 << CFG_IDX_BITS); i++)
        begin
            write_reg(CFG_IDX_BITS'(i), $urandom);
        end
        cfg_write <= 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();

        // longest ramp and stimulus, written with all data bits set
        write_reg(REG_RAMP_LEN, '1);
        write_reg(REG_TOTAL_LEN, '1);
        cfg_write <= 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();
    endtask

    // Random settings, each played from a restart to a little past its end, or for three to eight ticks when total > 40
    task automatic test_random(input int send_pct, input int stall_pct, input int goal);
        int                    first;
        int                    length;
        logic [MODE_BITS-1:0]  mode;
        logic [COUNT_BITS-1:0] ramp;
        logic [COUNT_BITS-1:0] total;
        first = ticks_sent;
        set_pressure(send_pct, stall_pct);
        while (ticks_sent - first < goal)
        begin
            mode  = MODE_BITS'($urandom_range(3));
            ramp  = random_length(8);
            total = random_length(24);
            program_regs({30'($urandom), mode}, draw_step(), draw_step(),
                         draw_step(), draw_step(), draw_step(),
                         {8'($urandom), ramp}, {8'($urandom), total});
            length = (total > 40) ? $urandom_range(3, 8) : total + $urandom_range(1, 3);
            send_tick(1'b1);
            for (int j = 1; j < length; j++)
            begin
                send_tick($urandom_range(99) < 6);
            end
            wait_idle();
        end
    endtask

    // Receiver holds off while ticks keep coming, so the block backs up
    task automatic test_backpressure();
        set_pressure(0, 0);
        program_regs(CFG_DATA_BITS'(MODE_AM), 32'h0321_0000, 32'h0040_0000,
                     0, 0, 0, 4, 20);
        hold_left <= HOLD_CYCLES;
        send_tick(1'b1);
        repeat (19) send_tick(1'b0);
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(0, 0, 85);
        test_random(58, 0, 85);
        test_random(0, 58, 85);
        test_random(19, 19, 85);
        test_backpressure();

        $display("Summary: %0d ticks sent, %0d samples checked over %0d register settings",
                 ticks_sent, samples_checked, settings_seen);
        $display("Summary: all modes, ramps, restarts, past-end ticks and receiver hold-off");
        if (errors == 0 && pending_samples.size() == 0)
        begin
            $display("ramped_multitone_stimulus_generator test passed");
        end
        else
        begin
            $display("ramped_multitone_stimulus_generator test failed");
        end
        $finish;
    end

endmodule

// ===== ramped_multitone_stimulus_generator.f =====
hdl/rmsg_pkg.sv
hdl/rmsg_dp.sv
hdl/rmsg_ctl.sv
hdl/ramped_multitone_stimulus_generator.sv
test/ramped_multitone_stimulus_generator_tb.sv
